// ===== rtl/dmh_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmh_pkg
// Shared constants and types of the dipole moment histogram.
// ---------------------------------------------------------------------------
package dmh_pkg;

    localparam int NumBinsDefault = 256;

    localparam logic [1:0] OP_PARTICLE = 2'd0;
    localparam logic [1:0] OP_READ     = 2'd1;
    localparam logic [1:0] OP_CLEAR    = 2'd2;

    localparam logic [1:0] REG_INV_BIN_WIDTH = 2'd0;
    localparam logic [1:0] REG_START_TIME    = 2'd1;
    localparam logic [1:0] REG_TIME_STEP     = 2'd2;

    localparam logic KIND_FRAME = 1'b0;
    localparam logic KIND_BIN   = 1'b1;

    // work item passed from the front end to the back end
    typedef struct packed {
        logic [1:0]  op;          // OP_READ, OP_CLEAR or OP_PARTICLE (group close or frame end)
        logic        frame_end;
        logic        group_end;
        logic [7:0]  bin_index;
        logic [39:0] gx;
        logic [39:0] gy;
        logic [39:0] gz;
        logic [39:0] fx;
        logic [39:0] fy;
        logic [39:0] fz;
    } t_task;

endpackage

// ===== rtl/dmh_ram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmh_ram
// Generic single-port RAM with registered read.
// ---------------------------------------------------------------------------
module dmh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/dmh_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmh_front
// Multiply charge by position, accumulate group and frame vectors, and
// hand group closes, frame ends, reads and clears to the back end.
// ---------------------------------------------------------------------------
module dmh_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    output logic                 o_full,
    input  logic [1:0]           i_operation,
    input  logic signed [11:0]   i_charge,
    input  logic signed [19:0]   i_pos_x,
    input  logic signed [19:0]   i_pos_y,
    input  logic signed [19:0]   i_pos_z,
    input  logic                 i_in_group,
    input  logic                 i_group_end,
    input  logic                 i_frame_end,
    input  logic [7:0]           i_bin_index,
    output logic                 o_valid,
    input  logic                 i_ready,
    output dmh_pkg::t_task       o_task
);
    // stage 1: registered products
    logic         r_s1_v;
    logic [1:0]   r_s1_op;
    logic         r_s1_ing, r_s1_gend, r_s1_fend;
    logic [7:0]   r_s1_bin;
    logic [39:0]  r_px, r_py, r_pz;
    // accumulators
    logic [39:0]  r_gx, r_gy, r_gz, r_fx, r_fy, r_fz;
    logic [39:0]  n_gx, n_gy, n_gz, n_fx, n_fy, n_fz;
    // output register
    logic            r_ov;
    dmh_pkg::t_task  r_task;
    logic            s1_fire, s1_emit, s1_part;

    assign o_full  = r_s1_v && !s1_fire;
    assign s1_part = (r_s1_op == dmh_pkg::OP_PARTICLE);
    assign s1_emit = (r_s1_op == dmh_pkg::OP_READ) || (r_s1_op == dmh_pkg::OP_CLEAR)
                     || (s1_part && ((r_s1_ing && r_s1_gend) || r_s1_fend));
    assign s1_fire = r_s1_v && (!s1_emit || !r_ov || i_ready);

    always_comb begin
        n_fx = r_fx + r_px;
        n_fy = r_fy + r_py;
        n_fz = r_fz + r_pz;
        n_gx = r_s1_ing ? r_gx + r_px : r_gx;
        n_gy = r_s1_ing ? r_gy + r_py : r_gy;
        n_gz = r_s1_ing ? r_gz + r_pz : r_gz;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_ov   <= 1'b0;
            r_gx <= '0; r_gy <= '0; r_gz <= '0;
            r_fx <= '0; r_fy <= '0; r_fz <= '0;
        end else begin
            if (r_ov && i_ready) begin
                r_ov <= 1'b0;
            end
            if (s1_fire) begin
                r_s1_v <= 1'b0;
                if (s1_part) begin
                    r_fx <= r_s1_fend ? '0 : n_fx;
                    r_fy <= r_s1_fend ? '0 : n_fy;
                    r_fz <= r_s1_fend ? '0 : n_fz;
                    r_gx <= (r_s1_ing && r_s1_gend) ? '0 : n_gx;
                    r_gy <= (r_s1_ing && r_s1_gend) ? '0 : n_gy;
                    r_gz <= (r_s1_ing && r_s1_gend) ? '0 : n_gz;
                end
                if (s1_emit) begin
                    r_ov <= 1'b1;
                end
            end
            if (i_push && !o_full) begin
                r_s1_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_s1_op   <= i_operation;
            r_s1_ing  <= i_in_group;
            r_s1_gend <= i_group_end;
            r_s1_fend <= i_frame_end;
            r_s1_bin  <= i_bin_index;
            r_px <= 40'(signed'(i_charge) * signed'(i_pos_x));
            r_py <= 40'(signed'(i_charge) * signed'(i_pos_y));
            r_pz <= 40'(signed'(i_charge) * signed'(i_pos_z));
        end
        if (s1_fire && s1_emit) begin
            r_task.op        <= r_s1_op;
            r_task.frame_end <= r_s1_fend;
            r_task.group_end <= r_s1_ing && r_s1_gend;
            r_task.bin_index <= r_s1_bin;
            r_task.gx <= n_gx; r_task.gy <= n_gy; r_task.gz <= n_gz;
            r_task.fx <= n_fx; r_task.fy <= n_fy; r_task.fz <= n_fz;
        end
    end

    assign o_valid = r_ov;
    assign o_task  = r_task;
endmodule

// ===== rtl/dmh_fifo.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmh_fifo
// Short queue of work items between the front and back ends.
// ---------------------------------------------------------------------------
module dmh_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dmh_pkg::t_task  i_task,
    output logic            o_valid,
    input  logic            i_ready,
    output dmh_pkg::t_task  o_task
);
    localparam int AW = $clog2(DEPTH);
    dmh_pkg::t_task r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;
    logic          wr, rd;

    assign o_ready = (r_cnt != (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign wr      = i_valid && o_ready;
    assign rd      = o_valid && i_ready;
    assign o_task  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= (r_wp == AW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (rd) begin
                r_rp <= (r_rp == AW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(wr) - (AW+1)'(rd);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_task;
        end
    end
endmodule

// ===== rtl/dmh_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dmh_back
// Sequencer for group binning, frame summaries, bin reads and clears.
// ---------------------------------------------------------------------------
module dmh_back #(
    parameter int NUM_BINS = dmh_pkg::NumBinsDefault
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  dmh_pkg::t_task  i_task,
    input  logic [31:0]     i_inv_bin_width,
    input  logic [31:0]     i_start_time,
    input  logic [31:0]     i_time_step,
    output logic            o_empty,
    input  logic            i_pop,
    output logic            o_kind,
    output logic [39:0]     o_total_x,
    output logic [39:0]     o_total_y,
    output logic [39:0]     o_total_z,
    output logic [62:0]     o_magnitude_squared,
    output logic [62:0]     o_frame_time,
    output logic [31:0]     o_bin_count
);
    localparam int BW = $clog2(NUM_BINS);

    localparam logic [3:0] ST_INIT   = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_SQ     = 4'd2;
    localparam logic [3:0] ST_SUM    = 4'd3;
    localparam logic [3:0] ST_ROOT   = 4'd4;
    localparam logic [3:0] ST_SCALE  = 4'd5;
    localparam logic [3:0] ST_HRD    = 4'd6;
    localparam logic [3:0] ST_HWR    = 4'd7;
    localparam logic [3:0] ST_FSQ    = 4'd8;
    localparam logic [3:0] ST_FSUM   = 4'd9;
    localparam logic [3:0] ST_FTIME  = 4'd10;
    localparam logic [3:0] ST_OUT    = 4'd11;
    localparam logic [3:0] ST_RD     = 4'd12;
    localparam logic [3:0] ST_RDW    = 4'd13;
    localparam logic [3:0] ST_CLR    = 4'd14;
    localparam logic [3:0] ST_BIN    = 4'd15;

    logic [3:0]  r_state;
    dmh_pkg::t_task r_t;
    logic [2:0]  r_sel;          // which square is being formed
    logic        r_half;         // low or high half of the square
    logic [79:0] r_sq;
    logic [81:0] r_acc;
    logic [5:0]  r_bit;
    logic [40:0] r_root;
    logic [81:0] r_rem;
    logic [63:0] r_prod;
    logic [40:0] r_hp;
    logic [BW-1:0] r_addr;
    logic [31:0] r_frame_count;
    logic        r_full;
    logic        r_kind;
    logic [39:0] r_ox, r_oy, r_oz;
    logic [62:0] r_mag, r_time;
    logic [31:0] r_cnt;
    logic [BW:0] r_clr;
    logic        r_oob;

    logic        we;
    logic [BW-1:0] addr;
    logic [31:0] wdata, rdata;
    logic [39:0] sq_src, sq_abs;
    logic [81:0] trial;
    logic [63:0] t_sum;
    logic [72:0] p_sum;

    dmh_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_hist (
        .i_clk(i_clk), .i_we(we), .i_addr(addr), .i_wdata(wdata), .o_rdata(rdata)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign o_empty = !r_full;
    assign o_kind = r_kind;
    assign o_total_x = r_ox;
    assign o_total_y = r_oy;
    assign o_total_z = r_oz;
    assign o_magnitude_squared = r_mag;
    assign o_frame_time = r_time;
    assign o_bin_count = r_cnt;

    always_comb begin
        case (r_sel)
            3'd0:    sq_src = r_t.gx;
            3'd1:    sq_src = r_t.gy;
            3'd2:    sq_src = r_t.gz;
            3'd3:    sq_src = r_t.fx;
            3'd4:    sq_src = r_t.fy;
            default: sq_src = r_t.fz;
        endcase
        sq_abs = sq_src[39] ? 40'(-sq_src) : sq_src;
        // restoring square root, one bit per cycle
        trial  = 82'({r_root, 2'b01}) << (2 * r_bit);
        t_sum  = r_prod + {32'd0, i_start_time};
        p_sum  = {r_hp, 32'd0} + {9'd0, r_prod};
        we    = 1'b0;
        addr  = r_addr;
        wdata = (rdata == 32'hFFFF_FFFF) ? rdata : rdata + 32'd1;
        case (r_state)
            ST_INIT, ST_CLR: begin
                we    = 1'b1;
                addr  = r_clr[BW-1:0];
                wdata = '0;
            end
            ST_HWR: we = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_INIT;
            r_clr         <= '0;
            r_full        <= 1'b0;
            r_frame_count <= '0;
        end else begin
            if (r_full && i_pop) begin
                r_full <= 1'b0;
            end
            case (r_state)
                ST_INIT, ST_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (BW+1)'(NUM_BINS-1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (i_valid) begin
                        case (i_task.op)
                            dmh_pkg::OP_READ:  r_state <= ST_RD;
                            dmh_pkg::OP_CLEAR: begin
                                r_state       <= ST_CLR;
                                r_clr         <= '0;
                                r_frame_count <= '0;
                            end
                            default: r_state <= i_task.group_end ? ST_SQ : ST_FSQ;
                        endcase
                    end
                end
                ST_SQ:   r_state <= r_half ? ST_SUM : ST_SQ;
                ST_SUM:  r_state <= (r_sel == 3'd2) ? ST_ROOT : ST_SQ;
                ST_ROOT: r_state <= (r_bit == 6'd0) ? ST_SCALE : ST_ROOT;
                ST_SCALE: r_state <= ST_BIN;
                ST_BIN:  r_state <= ST_HRD;
                ST_HRD:  r_state <= ST_HWR;
                ST_HWR:  r_state <= r_t.frame_end ? ST_FSQ : ST_IDLE;
                ST_FSQ:  r_state <= r_half ? ST_FSUM : ST_FSQ;
                ST_FSUM: begin
                    if (r_sel == 3'd5) begin
                        r_state       <= ST_FTIME;
                        r_frame_count <= r_frame_count + 32'd1;
                    end else begin
                        r_state <= ST_FSQ;
                    end
                end
                ST_FTIME: r_state <= ST_OUT;
                ST_OUT, ST_RDW: begin
                    if (!r_full || i_pop) begin
                        r_full  <= 1'b1;
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD:   r_state <= ST_RDW;
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_t    <= i_task;
                r_sel  <= i_task.group_end ? 3'd0 : 3'd3;
                r_half <= 1'b0;
                r_acc  <= '0;
                r_addr <= BW'(i_task.bin_index);
                r_oob  <= (32'(i_task.bin_index) >= 32'(NUM_BINS));
            end
            ST_SQ, ST_FSQ: begin
                r_half <= !r_half;
                if (!r_half) begin
                    r_sq <= 80'(sq_abs * sq_abs[19:0]);
                end else begin
                    r_sq <= r_sq + (80'(sq_abs * sq_abs[39:20]) << 20);
                end
            end
            ST_SUM, ST_FSUM: begin
                r_acc  <= r_acc + 82'(r_sq);
                r_sel  <= r_sel + 3'd1;
                r_bit  <= 6'd40;
                r_root <= '0;
                r_rem  <= r_acc + 82'(r_sq);
            end
            ST_ROOT: begin
                r_bit <= r_bit - 6'd1;
                if (r_rem >= trial) begin
                    r_rem  <= r_rem - trial;
                    r_root <= (r_root << 1) | 41'd1;
                end else begin
                    r_root <= r_root << 1;
                end
            end
            ST_SCALE: begin
                r_prod <= r_root[31:0] * i_inv_bin_width;
                r_hp   <= r_root[40:32] * i_inv_bin_width;
            end
            ST_BIN: begin
                r_addr <= (p_sum[72:36] >= 37'(NUM_BINS-1)) ? BW'(NUM_BINS-1)
                                                            : p_sum[BW+35:36];
            end
            ST_HWR: begin
                r_sel <= 3'd3;
                r_acc <= '0;
            end
            ST_FTIME: begin
                r_prod <= r_frame_count * i_time_step;
            end
            ST_OUT: begin
                if (!r_full || i_pop) begin
                    r_kind <= dmh_pkg::KIND_FRAME;
                    r_ox <= r_t.fx; r_oy <= r_t.fy; r_oz <= r_t.fz;
                    r_mag  <= {5'd0, r_acc[81:24]};
                    r_time <= (t_sum[63] || t_sum < r_prod) ? {63{1'b1}} : t_sum[62:0];
                    r_cnt <= '0;
                end
            end
            ST_RDW: begin
                if (!r_full || i_pop) begin
                    r_kind <= dmh_pkg::KIND_BIN;
                    r_ox <= '0; r_oy <= '0; r_oz <= '0;
                    r_mag <= '0; r_time <= '0;
                    r_cnt <= r_oob ? '0 : rdata;
                end
            end
            default: ;
        endcase
    end
endmodule

// ===== rtl/dipole_moment_histogram.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// dipole_moment_histogram
// Dipole moment totals per frame and group strength histogram.
// ---------------------------------------------------------------------------
// Particles enter a two-stage front end (product, then accumulate) at one per
// cycle while it is not full. Group closes, frame ends, bin reads and clears
// pass through a four-entry queue to a back-end sequencer: a group close forms
// a sum of squares, a bit-serial square root, then scale, bin select and a
// histogram read-modify-write; frame summaries, bin reads and clears have their
// own sequences, and a clear sweeps every bin through the single RAM port.
// After reset the histogram is swept to zero, during which queued work waits.
module dipole_moment_histogram #(
    parameter int NUM_BINS = dmh_pkg::NumBinsDefault
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  logic [1:0]         i_operation,
    input  logic signed [11:0] i_charge,
    input  logic signed [19:0] i_pos_x,
    input  logic signed [19:0] i_pos_y,
    input  logic signed [19:0] i_pos_z,
    input  logic               i_in_group,
    input  logic               i_group_end,
    input  logic               i_frame_end,
    input  logic [7:0]         i_bin_index,
    output logic               empty,
    input  logic               pop,
    output logic               o_kind,
    output logic signed [39:0] o_total_x,
    output logic signed [39:0] o_total_y,
    output logic signed [39:0] o_total_z,
    output logic [62:0]        o_magnitude_squared,
    output logic [62:0]        o_frame_time,
    output logic [31:0]        o_bin_count,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);
    logic [31:0] r_inv_bin_width, r_start_time, r_time_step;
    logic f_valid, f_ready, b_valid, b_ready;
    dmh_pkg::t_task f_task, b_task;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv_bin_width <= 32'd65536;
            r_start_time    <= '0;
            r_time_step     <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dmh_pkg::REG_INV_BIN_WIDTH: r_inv_bin_width <= i_cfg_data;
                dmh_pkg::REG_START_TIME:    r_start_time    <= i_cfg_data;
                dmh_pkg::REG_TIME_STEP:     r_time_step     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    dmh_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(push), .o_full(full),
        .i_operation(i_operation), .i_charge(i_charge),
        .i_pos_x(i_pos_x), .i_pos_y(i_pos_y), .i_pos_z(i_pos_z),
        .i_in_group(i_in_group), .i_group_end(i_group_end),
        .i_frame_end(i_frame_end), .i_bin_index(i_bin_index),
        .o_valid(f_valid), .i_ready(f_ready), .o_task(f_task)
    );

    dmh_fifo #(.DEPTH(4)) u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(f_valid), .o_ready(f_ready), .i_task(f_task),
        .o_valid(b_valid), .i_ready(b_ready), .o_task(b_task)
    );

    dmh_back #(.NUM_BINS(NUM_BINS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(b_valid), .o_ready(b_ready), .i_task(b_task),
        .i_inv_bin_width(r_inv_bin_width), .i_start_time(r_start_time),
        .i_time_step(r_time_step),
        .o_empty(empty), .i_pop(pop), .o_kind(o_kind),
        .o_total_x(o_total_x), .o_total_y(o_total_y), .o_total_z(o_total_z),
        .o_magnitude_squared(o_magnitude_squared), .o_frame_time(o_frame_time),
        .o_bin_count(o_bin_count)
    );

    a_frame_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == dmh_pkg::KIND_FRAME) |-> (o_bin_count == '0))
        else $error("frame summary with nonzero bin count");
    a_bin_zero_totals: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_kind == dmh_pkg::KIND_BIN) |-> (o_total_x == '0 && o_frame_time == '0))
        else $error("bin read with nonzero totals");
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_bin_count) && $stable(o_total_x)))
        else $error("waiting result changed");
endmodule
